// ===== rtl/lr_pkg.sv =====
`default_nettype none
package lr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int COLOUR_BITS = 24;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic [COORD_BITS-1:0]    first_x;
        logic [COORD_BITS-1:0]    first_y;
        logic [COORD_BITS-1:0]    second_x;
        logic [COORD_BITS-1:0]    second_y;
        logic [COLOUR_BITS-1:0]   line_colour;
    } in_beat_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]    pixel_x;
        logic [COORD_BITS-1:0]    pixel_y;
        logic [COLOUR_BITS-1:0]   pixel_colour;
        logic                     last_pixel;
    } out_beat_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]    cursor_x;
        logic [COORD_BITS-1:0]    cursor_y;
        logic signed [ERR_BITS-1:0] error_term;
        logic [COORD_BITS-1:0]    pixels_left;
        logic [COORD_BITS-1:0]    major_delta;
        logic [COORD_BITS-1:0]    minor_delta;
        logic                     x_is_major;
        logic                     x_goes_down;
        logic [COLOUR_BITS-1:0]   held_colour;
    } line_state_t;

endpackage
`default_nettype wire

// ===== rtl/lr_setup.sv =====
`default_nettype none
module lr_setup
    import lr_pkg::*;
(
    input  wire in_beat_t    beat,
    output line_state_t      state
);

    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] adx;
    logic                  down;
    logic                  xmaj;

    always_comb begin
        if (beat.first_y < beat.second_y) begin
            sx = beat.first_x;
            sy = beat.first_y;
            ex = beat.second_x;
            ey = beat.second_y;
        end else begin
            sx = beat.second_x;
            sy = beat.second_y;
            ex = beat.first_x;
            ey = beat.first_y;
        end
        dy   = ey - sy;
        down = ex < sx;
        adx  = down ? (sx - ex) : (ex - sx);
        xmaj = adx > dy;

        state.cursor_x    = sx;
        state.cursor_y    = sy;
        state.error_term  = '0;
        state.major_delta = xmaj ? adx : dy;
        state.minor_delta = xmaj ? dy : adx;
        state.pixels_left = xmaj ? adx : dy;
        state.x_is_major  = xmaj;
        state.x_goes_down = down;
        state.held_colour = beat.line_colour;
    end

endmodule
`default_nettype wire

// ===== rtl/lr_step.sv =====
`default_nettype none
module lr_step
    import lr_pkg::*;
(
    input  wire line_state_t cur,
    output line_state_t      nxt,
    output out_beat_t        pixel
);

    logic signed [ERR_BITS-1:0] err_sum;
    logic signed [ERR_BITS:0]   err_dbl;
    logic signed [ERR_BITS:0]   major_ext;
    logic                       minor_step;
    logic [COORD_BITS-1:0]      x_moved;

    always_comb begin
        err_sum    = cur.error_term + $signed({2'b00, cur.minor_delta});
        err_dbl    = {err_sum, 1'b0};
        major_ext  = $signed({3'b000, cur.major_delta});
        minor_step = err_dbl >= major_ext;
        x_moved    = cur.x_goes_down ? (cur.cursor_x - 1'b1) : (cur.cursor_x + 1'b1);

        nxt = cur;
        if (cur.x_is_major) begin
            nxt.cursor_x = x_moved;
            if (minor_step) begin
                nxt.cursor_y = cur.cursor_y + 1'b1;
            end
        end else begin
            nxt.cursor_y = cur.cursor_y + 1'b1;
            if (minor_step) begin
                nxt.cursor_x = x_moved;
            end
        end
        nxt.error_term  = minor_step ? (err_sum - $signed({2'b00, cur.major_delta}))
                                     : err_sum;
        nxt.pixels_left = cur.pixels_left - 1'b1;

        pixel.pixel_x      = cur.cursor_x;
        pixel.pixel_y      = cur.cursor_y;
        pixel.pixel_colour = cur.held_colour;
        pixel.last_pixel   = cur.pixels_left == {{(COORD_BITS-1){1'b0}}, 1'b1};
    end

endmodule
`default_nettype wire

// ===== rtl/line_rasterizer.sv =====
`default_nettype none
// Bresenham line stepper. A load beat (opcode OP_LOAD) takes two endpoints and a
// colour and gives no pixel; each step beat (OP_STEP) gives the next pixel of the
// line, starting at the endpoint with the smaller y (the second one on a tie), with
// last_pixel set on the final one. A line of max(|dx|,dy) pixels never draws its far
// endpoint; steps past the end give nothing, and a load drops any unfinished line.
// One beat is taken per clock while s_ready is high: the line state register and the
// pixel output register are updated as a beat is taken, so a pixel appears in the cycle
// after its step beat, and a beat is taken whenever the output register is empty or draining.
module line_rasterizer
    import lr_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_valid,
    output logic      s_ready,
    input  wire in_beat_t s_data,
    output logic      m_valid,
    input  wire       m_ready,
    output out_beat_t m_data
);

    line_state_t state_reg;
    line_state_t state_next;
    line_state_t load_state;
    line_state_t step_state;
    out_beat_t   step_pixel;
    out_beat_t   out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_fire;
    logic        have_pixel;

    lr_setup u_setup (
        .beat  (s_data),
        .state (load_state)
    );

    lr_step u_step (
        .cur   (state_reg),
        .nxt   (step_state),
        .pixel (step_pixel)
    );

    assign s_ready    = !out_valid_reg || m_ready;
    assign in_fire    = s_valid && s_ready;
    assign have_pixel = state_reg.pixels_left != '0;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (in_fire) begin
            case (s_data.opcode)
                OP_LOAD: begin
                    state_next = load_state;
                end
                OP_STEP: begin
                    if (have_pixel) begin
                        state_next     = step_state;
                        out_valid_next = 1'b1;
                    end
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_data.opcode == OP_STEP && have_pixel) begin
            out_reg <= step_pixel;
        end
    end

`ifndef ASSERT_OFF
    a_rise_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_fire && s_data.opcode == OP_STEP && have_pixel))
        else $error("pixel appeared without a step beat");

    a_load_clears_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_data.opcode == OP_LOAD) |=> state_reg.error_term == '0)
        else $error("error term not cleared by load");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_data.opcode == OP_STEP && step_pixel.last_pixel)
        |=> state_reg.pixels_left == '0 && m_data.last_pixel)
        else $error("line did not end after last pixel");

    a_idle_step_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_data.opcode == OP_STEP && !have_pixel) |=> $stable(state_reg))
        else $error("state moved on a step past the end");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_line_rasterizer.sv =====
`timescale 1ns / 1ps

module tb_line_rasterizer;
    import lr_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    line_rasterizer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // line state as the stepper should hold it
    logic [COORD_BITS-1:0]  cur_x, cur_y;
    int                     err_acc;
    logic [COORD_BITS-1:0]  px_left, maj_d, min_d;
    logic                   x_major, x_down;
    logic [COLOUR_BITS-1:0] line_col;

    out_beat_t pending_pixels[$];

    bit idle_en = 1'b1;
    int err_cnt = 0;
    int n_lines = 0, n_xmajor = 0, n_xdown = 0, n_steps = 0, n_pixels = 0, n_ends = 0;
    int stall_cycles = 0;

    task automatic report_error(input string msg);
        if (err_cnt < 50) $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic trace_line(input in_beat_t b);
        logic [COORD_BITS-1:0] sx, sy, ex, ey, adx, dy;
        out_beat_t px;
        if (b.opcode == OP_LOAD) begin
            if (b.first_y < b.second_y) begin
                sx = b.first_x;  sy = b.first_y;  ex = b.second_x; ey = b.second_y;
            end else begin
                sx = b.second_x; sy = b.second_y; ex = b.first_x;  ey = b.first_y;
            end
            dy = ey - sy;
            if (ex >= sx) begin
                adx = ex - sx;
                x_down = 1'b0;
            end else begin
                adx = sx - ex;
                x_down = 1'b1;
            end
            x_major = adx > dy;
            maj_d = x_major ? adx : dy;
            min_d = x_major ? dy : adx;
            px_left = maj_d;
            cur_x = sx;
            cur_y = sy;
            err_acc = 0;
            line_col = b.line_colour;
            n_lines++;
            if (x_major) n_xmajor++;
            if (x_down) n_xdown++;
        end else begin
            n_steps++;
            if (px_left != 0) begin
                px.pixel_x = cur_x;
                px.pixel_y = cur_y;
                px.pixel_colour = line_col;
                px.last_pixel = (px_left == 1);
                pending_pixels.push_back(px);
                err_acc += int'(min_d);
                if (x_major) begin
                    cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
                    if (2 * err_acc >= int'(maj_d)) begin
                        cur_y = cur_y + 1'b1;
                        err_acc -= int'(maj_d);
                    end
                end else begin
                    cur_y = cur_y + 1'b1;
                    if (2 * err_acc >= int'(maj_d)) begin
                        cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
                        err_acc -= int'(maj_d);
                    end
                end
                px_left = px_left - 1'b1;
            end
        end
    endtask

    // predicts on accepted input beats, then checks accepted output beats
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            cur_x = '0; cur_y = '0; err_acc = 0; px_left = '0;
            maj_d = '0; min_d = '0; x_major = 1'b0; x_down = 1'b0; line_col = '0;
        end else begin
            if (s_valid && s_ready) trace_line(s_data);
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    report_error($sformatf("unexpected pixel x=%0d y=%0d",
                                           m_data.pixel_x, m_data.pixel_y));
                end else begin
                    want = pending_pixels.pop_front();
                    n_pixels++;
                    if (want.last_pixel) n_ends++;
                    if (m_data.pixel_x !== want.pixel_x)
                        report_error($sformatf("pixel_x got %0d expected %0d",
                                               m_data.pixel_x, want.pixel_x));
                    if (m_data.pixel_y !== want.pixel_y)
                        report_error($sformatf("pixel_y got %0d expected %0d",
                                               m_data.pixel_y, want.pixel_y));
                    if (m_data.pixel_colour !== want.pixel_colour)
                        report_error($sformatf("pixel_colour got %06h expected %06h",
                                               m_data.pixel_colour, want.pixel_colour));
                    if (m_data.last_pixel !== want.last_pixel)
                        report_error($sformatf("last_pixel got %b expected %b at x=%0d y=%0d",
                                               m_data.last_pixel, want.last_pixel,
                                               want.pixel_x, want.pixel_y));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (idle_en && $urandom_range(99) < 19) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_beat(input in_beat_t b);
        while (idle_en && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic int iabs(input int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [COORD_BITS-1:0] near(input int c, input int d);
        int v;
        v = c + d;
        if (v < 0 || v > COORD_MAX) v = c - d;
        return v[COORD_BITS-1:0];
    endfunction

    task automatic draw_line(input int ax, input int ay, input int bx, input int by,
                             input logic [COLOUR_BITS-1:0] col, input int nsteps);
        in_beat_t b;
        b.opcode = OP_LOAD;
        b.first_x = COORD_BITS'(ax);
        b.first_y = COORD_BITS'(ay);
        b.second_x = COORD_BITS'(bx);
        b.second_y = COORD_BITS'(by);
        b.line_colour = col;
        send_beat(b);
        repeat (nsteps) begin
            b.opcode = OP_STEP;
            b.first_x = COORD_BITS'($urandom);
            b.first_y = COORD_BITS'($urandom);
            b.second_x = COORD_BITS'($urandom);
            b.second_y = COORD_BITS'($urandom);
            b.line_colour = COLOUR_BITS'($urandom);
            send_beat(b);
        end
    endtask

    task automatic test_directed();
        in_beat_t b;
        // step straight out of reset: nothing to draw
        b = '0;
        b.opcode = OP_STEP;
        send_beat(b);
        // zero-length line
        draw_line(7, 9, 7, 9, 24'h000000, 1);
        // equal y: second point starts, x falls
        draw_line(0, 5, 3, 5, 24'hFFFFFF, 4);
        // vertical line, then a step past its end
        draw_line(10, 0, 10, 4, 24'h123456, 5);
        // full-range diagonals, each dropped by the next load
        draw_line(4095, 4095, 0, 0, 24'hA5A5A5, 3);
        draw_line(4095, 0, 0, 4095, 24'h5A5A5A, 2);
        // x-major falling with a one-row rise
        draw_line(0, 4095, 4095, 4094, 24'hC0FFEE, 1);
        // shallow rising line to the end
        draw_line(1, 2, 6, 4, 24'h0F0F0F, 5);
    endtask

    task automatic test_random_lines(input int n_items);
        int useful, ax, ay, bx, by, len, nsteps, r;
        in_beat_t b;
        useful = 0;
        while (useful < n_items) begin
            r = $urandom_range(99);
            if (r < 5) begin
                b.opcode = OP_STEP;
                b.first_x = COORD_BITS'($urandom);
                b.first_y = COORD_BITS'($urandom);
                b.second_x = COORD_BITS'($urandom);
                b.second_y = COORD_BITS'($urandom);
                b.line_colour = COLOUR_BITS'($urandom);
                send_beat(b);
            end else begin
                ax = $urandom_range(COORD_MAX);
                ay = $urandom_range(COORD_MAX);
                if ($urandom_range(39) == 0) begin
                    bx = $urandom_range(COORD_MAX);
                    by = $urandom_range(COORD_MAX);
                end else begin
                    bx = int'(near(ax, $urandom_range(80) - 40));
                    by = int'(near(ay, $urandom_range(80) - 40));
                    if ($urandom_range(9) == 0) by = ay;
                end
                len = iabs(bx - ax) > iabs(by - ay) ? iabs(bx - ax) : iabs(by - ay);
                if (len > 64) begin
                    nsteps = $urandom_range(60, 1);
                end else if (r < 80) begin
                    nsteps = len + $urandom_range(2);
                end else begin
                    nsteps = $urandom_range(len);
                end
                draw_line(ax, ay, bx, by, COLOUR_BITS'($urandom), nsteps);
                useful += 1 + (nsteps < len ? nsteps : len);
            end
        end
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        test_random_lines(300);
        idle_en = 1'b1;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_lines(700);
        test_back_to_back();
        test_random_lines(400);

        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("Drew %0d lines (%0d x-major, %0d with x falling) over %0d step beats",
                 n_lines, n_xmajor, n_xdown, n_steps);
        $display("Checked %0d pixels, %0d of them line ends; %0d mismatches",
                 n_pixels, n_ends, err_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lr_pkg.sv
rtl/lr_setup.sv
rtl/lr_step.sv
rtl/line_rasterizer.sv
tb/tb_line_rasterizer.sv
